### hw/rtl/mru_stack_with_cycle_cursor_top_macros.svh
// assertion macros for the mru stack with cycle cursor block
`ifndef MRU_STACK_WITH_CYCLE_CURSOR_TOP_MACROS_SVH
`define MRU_STACK_WITH_CYCLE_CURSOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds in the same cycle as its trigger
`define MSCC_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("mscc assertion failed");

// condition holds in the cycle after its trigger
`define MSCC_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("mscc assertion failed");

`else

`define MSCC_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define MSCC_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

### hw/rtl/mscc_pkg.sv
// shared constants and types for the mru stack with cycle cursor block
package mscc_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int LIVE_W    = 5;
    localparam int DEPTH_W   = 5;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int TDATA_W   = 16;

    // event codes carried in the action field
    typedef enum logic [1:0] {
        ACT_VISIT   = 2'd0,
        ACT_STEP    = 2'd1,
        ACT_COMMIT  = 2'd2,
        ACT_RESOLVE = 2'd3
    } mscc_action_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              promote_en;
        logic              prune_en;
        logic [SLOT_W-1:0] slot;
        logic [LIVE_W-1:0] live;
        logic [CNT_W-1:0]  count;
    } mscc_cell_ctl_t;

    // ripple flags passed from a cell to the next one down the stack
    typedef struct packed {
        logic found;
        logic hole;
    } mscc_link_t;

endpackage

### hw/rtl/mscc_cell.sv
// one stack position: holds an entry and moves it to a neighbor on promote or prune
module mscc_cell (
    input  logic                          clk,
    input  mscc_pkg::mscc_cell_ctl_t      ctl,
    input  mscc_pkg::mscc_link_t          link_in,
    output mscc_pkg::mscc_link_t          link_out,
    input  logic [mscc_pkg::CNT_W-1:0]    idx,
    input  logic [mscc_pkg::SLOT_W-1:0]   left_entry,
    input  logic [mscc_pkg::SLOT_W-1:0]   right_entry,
    output logic [mscc_pkg::SLOT_W-1:0]   entry
);
    import mscc_pkg::*;

    logic [SLOT_W-1:0] entry_reg;
    logic [SLOT_W-1:0] entry_next;
    logic              occupied;
    logic              match;
    logic              kill;

    // position holds a live stack entry
    assign occupied = idx < ctl.count;
    assign match    = occupied && (entry_reg == ctl.slot);
    assign kill     = occupied && (LIVE_W'(entry_reg) >= ctl.live);

    // flags ripple toward the bottom of the stack
    assign link_out.found = link_in.found | match;
    assign link_out.hole  = link_in.hole | kill;

    // shift down above the match on promote, shift up from the first hole on prune
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.promote_en && !link_in.found)
        begin
            entry_next = left_entry;
        end
        else if (ctl.prune_en && (link_in.hole || kill))
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### hw/rtl/mru_stack_with_cycle_cursor_top.sv
// Most-recently-used stack of up to 16 distinct slot numbers with a cycling
// cursor, built as a row of cells that shift entries to their neighbors. One
// transaction is taken at a time and returns exactly one result transaction.
// A known visit, or a commit with the cursor inside the stack, promotes; a step
// outside a session or a resolve removes one out-of-range entry per cycle (up
// to 16) in a prune pass, then promotes if the slot is known, and a step inside
// a session of two or more entries wraps its cursor by repeated subtraction.
// The input is taken only while the sequencer is idle; a finished result sits
// in the output register and does not hold back the next input transaction.
// The stack needs no clearing pass after reset.
`include "mru_stack_with_cycle_cursor_top_macros.svh"

module mru_stack_with_cycle_cursor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], current_slot[5:2], current_known[6], live_count[11:7],
    // carry_request[12], zero[15:13]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // target_valid[0], target_slot[4:1], switch_request[5], carry_window[6],
    // cycling_active[7], stack_depth[12:8], zero[15:13]
    output logic [15:0] m_axis_tdata
);
    import mscc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRUNE,
        ST_PROMOTE,
        ST_MOD,
        ST_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               session_reg, session_next;
    logic [IDX_W-1:0]   cursor_reg, cursor_next;
    logic [CNT_W-1:0]   wrap_reg, wrap_next;
    mscc_action_t       act_reg, act_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic               known_reg, known_next;
    logic [LIVE_W-1:0]  live_reg, live_next;
    logic               carry_reg, carry_next;
    logic               sess_start_reg, sess_start_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;

    mscc_cell_ctl_t     cell_ctl;
    mscc_link_t         link [MAX_SLOTS+1];
    logic [SLOT_W-1:0]  entry_w [MAX_SLOTS];
    logic [SLOT_W-1:0]  left_w  [MAX_SLOTS];
    logic [SLOT_W-1:0]  right_w [MAX_SLOTS];

    logic               in_fire;
    logic               out_free;
    mscc_action_t       in_act;
    logic [IDX_W-1:0]   rd_addr;
    logic [SLOT_W-1:0]  rd_data;
    logic               two_or_more;
    logic               res_valid;
    logic               res_sw;
    logic               res_cw;

    // handshake
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign in_act        = mscc_action_t'(s_axis_tdata[1:0]);

    // broadcast control to the cell row
    assign cell_ctl.promote_en = (state_reg == ST_PROMOTE);
    assign cell_ctl.prune_en   = (state_reg == ST_PRUNE);
    assign cell_ctl.slot       = slot_reg;
    assign cell_ctl.live       = live_reg;
    assign cell_ctl.count      = count_reg;
    assign link[0]             = '0;

    // row of cells, entry 0 is the most recent slot
    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_w[i] = slot_reg;
        end
        else
        begin : g_body
            assign left_w[i] = entry_w[i-1];
        end
        if (i == MAX_SLOTS - 1)
        begin : g_tail
            assign right_w[i] = entry_w[i];
        end
        else
        begin : g_inner
            assign right_w[i] = entry_w[i+1];
        end

        mscc_cell u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .link_in     (link[i]),
            .link_out    (link[i+1]),
            .idx         (CNT_W'(i)),
            .left_entry  (left_w[i]),
            .right_entry (right_w[i]),
            .entry       (entry_w[i])
        );
    end

    // single read port: the cursor entry, or the second entry for new sessions and resolve
    assign rd_addr = ((state_reg == ST_RESULT) &&
                      ((act_reg == ACT_RESOLVE) || !sess_start_reg)) ?
                     IDX_W'(1) : cursor_reg;
    assign rd_data = entry_w[rd_addr];

    // result fields
    assign two_or_more = (count_reg >= CNT_W'(2));
    always_comb
    begin
        res_valid = 1'b0;
        res_sw    = 1'b0;
        res_cw    = 1'b0;
        unique case (act_reg)
            ACT_STEP:
            begin
                res_valid = two_or_more && (sess_start_reg || known_reg);
                res_cw    = res_valid && carry_reg;
                res_sw    = res_valid && (!known_reg || (rd_data != cur_reg)) &&
                            (LIVE_W'(rd_data) < live_reg);
            end
            ACT_RESOLVE:
            begin
                res_valid = known_reg && two_or_more;
            end
            ACT_VISIT, ACT_COMMIT:
            begin
                res_valid = 1'b0;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        session_next    = session_reg;
        cursor_next     = cursor_reg;
        wrap_next       = wrap_reg;
        act_next        = act_reg;
        cur_next        = cur_reg;
        known_next      = known_reg;
        live_next       = live_reg;
        carry_next      = carry_reg;
        sess_start_next = sess_start_reg;
        slot_next       = slot_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    act_next        = in_act;
                    cur_next        = s_axis_tdata[5:2];
                    known_next      = s_axis_tdata[6];
                    live_next       = s_axis_tdata[11:7];
                    carry_next      = s_axis_tdata[12];
                    sess_start_next = session_reg;
                    slot_next       = (in_act == ACT_COMMIT) ? rd_data : s_axis_tdata[5:2];
                    unique case (in_act)
                        ACT_VISIT:
                        begin
                            state_next = s_axis_tdata[6] ? ST_PROMOTE : ST_RESULT;
                        end
                        ACT_STEP:
                        begin
                            if (!session_reg)
                            begin
                                state_next = ST_PRUNE;
                            end
                            else if (two_or_more)
                            begin
                                wrap_next  = CNT_W'(cursor_reg) + CNT_W'(1);
                                state_next = ST_MOD;
                            end
                            else
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                        ACT_COMMIT:
                        begin
                            session_next = 1'b0;
                            state_next   = (CNT_W'(cursor_reg) < count_reg) ?
                                           ST_PROMOTE : ST_RESULT;
                        end
                        ACT_RESOLVE:
                        begin
                            state_next = ST_PRUNE;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            // drop the first out-of-range entry each cycle
            ST_PRUNE:
            begin
                if (link[MAX_SLOTS].hole)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = known_reg ? ST_PROMOTE : ST_RESULT;
                end
            end

            // move the slot to the front, growing the stack if it was not held and the stack is not full
            ST_PROMOTE:
            begin
                if (!link[MAX_SLOTS].found && (count_reg < CNT_W'(MAX_SLOTS)))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_RESULT;
            end

            // cursor wrap by repeated subtraction
            ST_MOD:
            begin
                if (wrap_reg >= count_reg)
                begin
                    wrap_next = wrap_reg - count_reg;
                end
                else
                begin
                    cursor_next = IDX_W'(wrap_reg);
                    state_next  = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    if ((act_reg == ACT_STEP) && !sess_start_reg && res_valid)
                    begin
                        session_next = 1'b1;
                        cursor_next  = IDX_W'(1);
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000,
                                      DEPTH_W'(count_reg),
                                      session_next,
                                      res_cw,
                                      res_sw,
                                      res_valid ? rd_data : SLOT_W'(0),
                                      res_valid};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            session_reg   <= 1'b0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            session_reg   <= session_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wrap_reg       <= wrap_next;
        act_reg        <= act_next;
        cur_reg        <= cur_next;
        known_reg      <= known_next;
        live_reg       <= live_next;
        carry_reg      <= carry_next;
        sess_start_reg <= sess_start_next;
        slot_reg       <= slot_next;
        out_data_reg   <= out_data_next;
    end

    // checks
    `MSCC_ASSERT_SAME(a_depth_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_SLOTS))
    `MSCC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, state_reg != ST_IDLE)
    `MSCC_ASSERT_NEXT(a_promote_no_shrink, clk, rst_n, state_reg == ST_PROMOTE, count_reg >= $past(count_reg))
    `MSCC_ASSERT_SAME(a_wrap_depth, clk, rst_n, state_reg == ST_MOD, count_reg >= CNT_W'(2))

endmodule
